>>> rtl/core/name_channel_registry_table_macros.svh
// Assertion macros for the name channel registry table checker.
// Used by ncrt_checker.sv; expects signals named clk and rst_n in scope.
`ifndef NAME_CHANNEL_REGISTRY_TABLE_MACROS_SVH
`define NAME_CHANNEL_REGISTRY_TABLE_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define NCRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication built on the macro above.
`define NCRT_IMPLY(lbl, ante, cons, msg) \
  `NCRT_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

>>> rtl/core/ncrt_pkg.sv
// Shared types and constants for the name channel registry table.
// No dependencies; used by every module of the block.
package ncrt_pkg;

  localparam int unsigned ENTRIES    = 64;
  localparam int unsigned NAME_WORDS = 8;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned CHAN_W     = 64;
  localparam int unsigned MAGIC_W    = 32;
  localparam int unsigned CMD_W      = 16;
  localparam int unsigned LEN_W      = 16;

  localparam int unsigned NAME_BYTES = NAME_WORDS * 8;
  localparam int unsigned NAME_BITS  = NAME_WORDS * WORD_W;
  localparam int unsigned ADDR_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W      = $clog2(ENTRIES + 1);
  localparam int unsigned WIDX_W     = (NAME_WORDS > 1) ? $clog2(NAME_WORDS) : 1;
  localparam int unsigned WCNT_W     = $clog2(NAME_WORDS + 1);

  localparam logic [CMD_W-1:0] CMD_REGISTER = 16'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP   = 16'd1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_REJECT    = 2'd2
  } status_t;

  typedef logic [NAME_WORDS-1:0][WORD_W-1:0] key_t;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [MAGIC_W-1:0] magic;
    logic [LEN_W-1:0]   key_len;
    logic [CHAN_W-1:0]  channel;
    logic [WORD_W-1:0]  key_word;
    logic               word_last;
  } in_t;

  typedef struct packed {
    status_t           status;
    logic [CHAN_W-1:0] channel_out;
  } out_t;

  typedef struct packed {
    logic              name_we;
    logic              chan_we;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
  } store_ctl_t;

endpackage

>>> rtl/core/ncrt_keybuf.sv
// Name word collector: buffers incoming name words with zero-byte cutoff
// and produces the length-masked search key. Depends on ncrt_pkg.
module ncrt_keybuf (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      word_we,
  input  logic [ncrt_pkg::WORD_W-1:0] word,
  input  logic                      take,
  input  logic [ncrt_pkg::LEN_W-1:0]  key_len,
  output ncrt_pkg::key_t            key
);

  ncrt_pkg::key_t                    words_r;
  ncrt_pkg::key_t                    key_r;
  ncrt_pkg::key_t                    key_nxt;
  logic [ncrt_pkg::WCNT_W-1:0]       wcnt_r;
  logic                              ended_r;
  logic [ncrt_pkg::WORD_W-1:0]       zword;
  logic                              run_end;

  // Once a zero byte has been seen, every later byte of the name is zero.
  always_comb begin
    zword   = '0;
    run_end = ended_r;
    for (int b = 0; b < 8; b++) begin
      if (word[8*b +: 8] == 8'd0) begin
        run_end = 1'b1;
      end
      if (!run_end) begin
        zword[8*b +: 8] = word[8*b +: 8];
      end
    end
  end

  // Bytes at or beyond the declared length are cleared.
  always_comb begin
    key_nxt = '0;
    for (int w = 0; w < int'(ncrt_pkg::NAME_WORDS); w++) begin
      for (int b = 0; b < 8; b++) begin
        if (ncrt_pkg::LEN_W'(w * 8 + b) < key_len) begin
          key_nxt[w][8*b +: 8] = words_r[w][8*b +: 8];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      words_r <= '0;
      wcnt_r  <= '0;
      ended_r <= 1'b0;
    end else if (take) begin
      words_r <= '0;
      wcnt_r  <= '0;
      ended_r <= 1'b0;
    end else if (word_we && (wcnt_r < ncrt_pkg::WCNT_W'(ncrt_pkg::NAME_WORDS))) begin
      words_r[wcnt_r[ncrt_pkg::WIDX_W-1:0]] <= zword;
      wcnt_r  <= wcnt_r + 1'b1;
      ended_r <= run_end;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      key_r <= key_nxt;
    end
  end

  assign key = key_r;

endmodule

>>> rtl/core/ncrt_store.sv
// Entry storage: wide name memory, channel memory and the shared key
// comparator used by the search sequencer. Depends on ncrt_pkg.
module ncrt_store (
  input  logic                        clk,
  input  ncrt_pkg::store_ctl_t        ctl,
  input  ncrt_pkg::key_t              key,
  input  logic [ncrt_pkg::CHAN_W-1:0] chan_wdata,
  output logic                        match,
  output logic [ncrt_pkg::CHAN_W-1:0] chan_rdata
);

  logic [ncrt_pkg::NAME_BITS-1:0] name_mem [ncrt_pkg::ENTRIES];
  logic [ncrt_pkg::CHAN_W-1:0]    chan_mem [ncrt_pkg::ENTRIES];
  logic [ncrt_pkg::NAME_BITS-1:0] name_rd_r;
  logic [ncrt_pkg::CHAN_W-1:0]    chan_rd_r;

  always_ff @(posedge clk) begin
    if (ctl.name_we) begin
      name_mem[ctl.waddr] <= key;
    end
    name_rd_r <= name_mem[ctl.raddr];
  end

  always_ff @(posedge clk) begin
    if (ctl.chan_we) begin
      chan_mem[ctl.waddr] <= chan_wdata;
    end
    chan_rd_r <= chan_mem[ctl.raddr];
  end

  // One whole stored name is compared against the key per cycle.
  assign match      = (name_rd_r == key);
  assign chan_rdata = chan_rd_r;

endmodule

>>> rtl/core/name_channel_registry_table.sv
// Top level of the name channel registry table. Depends on ncrt_pkg,
// ncrt_keybuf and ncrt_store.
//
// The block keeps a table of up to 64 names, each up to 63 bytes, mapped
// to 64-bit channel ids. A request arrives as a run of 8-byte name word
// transfers, the final one flagged by word_last; cmd, magic, key_len and
// channel are sampled only on that final transfer. Name bytes at or past
// the declared length, and all bytes after the first zero byte, are
// treated as zero. A request whose magic differs from the configured value
// produces no result. Otherwise exactly one result transfer follows:
// register updates a matching entry or appends a new one and echoes the
// channel, lookup returns the stored channel or not-found, and a bad
// command, a length of zero or of 64 and above, or a register into a full
// table is rejected with a zero channel. After the final word the input is
// held off while the key is masked, the table is searched, the channel of
// a hit is fetched and the result is written; a rejected request skips the
// search and a request with a wrong magic returns to idle after masking.
// The search walks the name memory one entry per cycle, reading a full
// 512-bit name row and comparing it in a single shared comparator. The
// finish step is stretched for as long as an earlier result still waits
// in the output register. That register lets the block take the words of
// the next request while a result still waits; it only holds off
// finishing a request until the previous result has been transferred. The
// magic register may be written at any time the block is idle and is
// always ready.
module name_channel_registry_table (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  ncrt_pkg::in_t                in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output ncrt_pkg::out_t               out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ncrt_pkg::MAGIC_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MASK,
    S_SEARCH,
    S_FETCH,
    S_FINISH
  } state_t;

  state_t                        state_r, state_nxt;
  logic [ncrt_pkg::MAGIC_W-1:0]  magic_cfg_r;
  logic [ncrt_pkg::CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [ncrt_pkg::LEN_W-1:0]    len_r, len_nxt;
  logic [ncrt_pkg::CHAN_W-1:0]   chan_r, chan_nxt;
  logic                          magic_ok_r, magic_ok_nxt;
  logic                          reject_r, reject_nxt;
  logic [ncrt_pkg::CNT_W-1:0]    issue_r, issue_nxt;
  logic                          pend_r, pend_nxt;
  logic [ncrt_pkg::ADDR_W-1:0]   pend_idx_r, pend_idx_nxt;
  logic [ncrt_pkg::ADDR_W-1:0]   hit_r, hit_nxt;
  logic                          found_r, found_nxt;
  logic [ncrt_pkg::CNT_W-1:0]    entry_count_r, entry_count_nxt;
  logic                          out_valid_r, out_valid_nxt;
  ncrt_pkg::out_t                out_data_r, out_data_nxt;

  logic                          in_xfer;
  logic                          take;
  ncrt_pkg::key_t                key;
  ncrt_pkg::store_ctl_t          ctl;
  logic                          match;
  logic [ncrt_pkg::CHAN_W-1:0]   chan_rdata;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign take      = (state_r == S_MASK);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  ncrt_keybuf u_keybuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .word_we  (in_xfer),
    .word     (in_data.key_word),
    .take     (take),
    .key_len  (len_r),
    .key      (key)
  );

  ncrt_store u_store (
    .clk        (clk),
    .ctl        (ctl),
    .key        (key),
    .chan_wdata (chan_r),
    .match      (match),
    .chan_rdata (chan_rdata)
  );

  always_comb begin
    state_nxt       = state_r;
    cmd_nxt         = cmd_r;
    len_nxt         = len_r;
    chan_nxt        = chan_r;
    magic_ok_nxt    = magic_ok_r;
    reject_nxt      = reject_r;
    issue_nxt       = issue_r;
    pend_nxt        = pend_r;
    pend_idx_nxt    = pend_idx_r;
    hit_nxt         = hit_r;
    found_nxt       = found_r;
    entry_count_nxt = entry_count_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_data_nxt    = out_data_r;

    ctl         = '0;
    // While fetching or finishing, the read port stays on the matched
    // entry so its channel is held through an output stall.
    if ((state_r == S_FETCH) || (state_r == S_FINISH)) begin
      ctl.raddr = hit_r;
    end else begin
      ctl.raddr = issue_r[ncrt_pkg::ADDR_W-1:0];
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer && in_data.word_last) begin
          cmd_nxt      = in_data.cmd;
          len_nxt      = in_data.key_len;
          chan_nxt     = in_data.channel;
          magic_ok_nxt = (in_data.magic == magic_cfg_r);
          state_nxt    = S_MASK;
        end
      end
      S_MASK: begin
        // The key buffer latches the masked key and clears itself here.
        reject_nxt = ((cmd_r != ncrt_pkg::CMD_REGISTER) && (cmd_r != ncrt_pkg::CMD_LOOKUP))
                     || (len_r == '0)
                     || (len_r >= ncrt_pkg::LEN_W'(ncrt_pkg::NAME_BYTES));
        issue_nxt  = '0;
        pend_nxt   = 1'b0;
        found_nxt  = 1'b0;
        if (!magic_ok_r) begin
          state_nxt = S_IDLE;
        end else if (reject_nxt) begin
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        // Reads are issued one entry ahead of the compare.
        if (pend_r && match) begin
          found_nxt = 1'b1;
          hit_nxt   = pend_idx_r;
          state_nxt = S_FETCH;
        end else if (issue_r < entry_count_r) begin
          pend_nxt     = 1'b1;
          pend_idx_nxt = issue_r[ncrt_pkg::ADDR_W-1:0];
          issue_nxt    = issue_r + 1'b1;
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_FETCH: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (reject_r) begin
            out_data_nxt.status      = ncrt_pkg::ST_REJECT;
            out_data_nxt.channel_out = '0;
          end else if (cmd_r == ncrt_pkg::CMD_REGISTER) begin
            if (found_r) begin
              ctl.chan_we              = 1'b1;
              ctl.waddr                = hit_r;
              out_data_nxt.status      = ncrt_pkg::ST_OK;
              out_data_nxt.channel_out = chan_r;
            end else if (entry_count_r < ncrt_pkg::CNT_W'(ncrt_pkg::ENTRIES)) begin
              ctl.name_we              = 1'b1;
              ctl.chan_we              = 1'b1;
              ctl.waddr                = entry_count_r[ncrt_pkg::ADDR_W-1:0];
              entry_count_nxt          = entry_count_r + 1'b1;
              out_data_nxt.status      = ncrt_pkg::ST_OK;
              out_data_nxt.channel_out = chan_r;
            end else begin
              out_data_nxt.status      = ncrt_pkg::ST_REJECT;
              out_data_nxt.channel_out = '0;
            end
          end else if (found_r) begin
            out_data_nxt.status      = ncrt_pkg::ST_OK;
            out_data_nxt.channel_out = chan_rdata;
          end else begin
            out_data_nxt.status      = ncrt_pkg::ST_NOT_FOUND;
            out_data_nxt.channel_out = '0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      magic_cfg_r   <= '0;
      entry_count_r <= '0;
      out_valid_r   <= 1'b0;
      pend_r        <= 1'b0;
      found_r       <= 1'b0;
      reject_r      <= 1'b0;
      magic_ok_r    <= 1'b0;
      issue_r       <= '0;
    end else begin
      state_r       <= state_nxt;
      entry_count_r <= entry_count_nxt;
      out_valid_r   <= out_valid_nxt;
      pend_r        <= pend_nxt;
      found_r       <= found_nxt;
      reject_r      <= reject_nxt;
      magic_ok_r    <= magic_ok_nxt;
      issue_r       <= issue_nxt;
      if (cfg_valid && cfg_ready) begin
        magic_cfg_r <= cfg_data;
      end
    end
    cmd_r      <= cmd_nxt;
    len_r      <= len_nxt;
    chan_r     <= chan_nxt;
    pend_idx_r <= pend_idx_nxt;
    hit_r      <= hit_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

>>> rtl/core/ncrt_checker.sv
// Port-level checks for the name channel registry table, bound to the top.
// Depends on ncrt_pkg and name_channel_registry_table_macros.svh.
`include "name_channel_registry_table_macros.svh"

module ncrt_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input ncrt_pkg::in_t                in_data,
  input logic                         out_valid,
  input logic                         out_ready,
  input ncrt_pkg::out_t               out_data
);

  // A stalled result must hold.
  `NCRT_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_data)), "result changed while stalled")

  // Errors and misses always carry a zero channel.
  `NCRT_IMPLY(a_err_zero, (out_valid && (out_data.status != ncrt_pkg::ST_OK)), (out_data.channel_out == '0), "nonzero channel on error")

  // The final word of a request always starts a busy period.
  `NCRT_ASSERT(a_last_busy, (in_valid && in_ready && in_data.word_last) |=> !in_ready, "ready right after final word")

  // A new result only appears at the end of a busy period.
  `NCRT_IMPLY(a_out_busy, $rose(out_valid), $past(!in_ready), "result without request processing")

endmodule

bind name_channel_registry_table ncrt_checker u_ncrt_checker (.*);

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the name channel registry table: a scoreboard class
// mirrors the table and checks every reply. Depends on ncrt_pkg and the block.
module tb_top;

  // Cycles without any transfer on any channel before the run is abandoned.
  localparam int unsigned STALL_LIMIT = 20000;
  // Cycles left after the last reply so that a request that gives no reply,
  // such as one with a wrong magic, has been dropped by the block.
  localparam int unsigned SETTLE      = 100;
  // Receiver hold-off during the back-pressure phase.
  localparam int unsigned LONG_HOLD   = 500;
  localparam int unsigned POOL        = 96;
  localparam int unsigned ITEMS       = 1450;

  // Mirror of the registry. Every accepted word goes through note_transfer,
  // which queues the reply the block owes for a completed request.
  class registry_scoreboard;
    logic [ncrt_pkg::MAGIC_W-1:0] magic_cfg;
    logic [ncrt_pkg::WORD_W-1:0]  word_buf [ncrt_pkg::NAME_WORDS];
    int unsigned                  words_seen;
    ncrt_pkg::key_t               names [ncrt_pkg::ENTRIES];
    logic [ncrt_pkg::CHAN_W-1:0]  chans [ncrt_pkg::ENTRIES];
    int unsigned                  used;
    ncrt_pkg::out_t               replies_due [$];
    int unsigned                  mismatches;
    int unsigned                  checked;

    function new();
      magic_cfg  = '0;
      used       = 0;
      mismatches = 0;
      checked    = 0;
      drop_request();
    endfunction

    function void drop_request();
      for (int i = 0; i < ncrt_pkg::NAME_WORDS; i++) word_buf[i] = '0;
      words_seen = 0;
    endfunction

    function void set_magic(logic [ncrt_pkg::MAGIC_W-1:0] v);
      magic_cfg = v;
    endfunction

    function int unsigned replies_pending();
      return replies_due.size();
    endfunction

    function void note_transfer(ncrt_pkg::in_t it);
      ncrt_pkg::key_t key;
      logic [7:0]     byt;
      bit             ended;
      bit             hit;
      int unsigned    idx;
      ncrt_pkg::out_t r;
      // Words past the key width are dropped, though the count saturates.
      if (words_seen < ncrt_pkg::NAME_WORDS) begin
        word_buf[words_seen] = it.key_word;
        words_seen++;
      end
      if (!it.word_last) return;
      if (it.magic != magic_cfg) begin
        drop_request();
        return;
      end
      // The name ends at the declared length or at the first zero byte,
      // whichever comes first; everything after it is zero.
      key   = '0;
      ended = 1'b0;
      for (int unsigned b = 0; b < ncrt_pkg::NAME_BYTES; b++) begin
        byt = word_buf[b / 8][(b % 8) * 8 +: 8];
        if (b >= it.key_len || byt == 8'h00) ended = 1'b1;
        if (!ended) key[b / 8][(b % 8) * 8 +: 8] = byt;
      end
      drop_request();
      r.status      = ncrt_pkg::ST_OK;
      r.channel_out = '0;
      if ((it.cmd != ncrt_pkg::CMD_REGISTER && it.cmd != ncrt_pkg::CMD_LOOKUP) ||
          it.key_len == 0 || it.key_len >= ncrt_pkg::NAME_BYTES) begin
        r.status = ncrt_pkg::ST_REJECT;
      end else begin
        hit = 1'b0;
        idx = 0;
        for (int unsigned e = 0; e < used && !hit; e++) begin
          if (names[e] == key) begin
            hit = 1'b1;
            idx = e;
          end
        end
        if (it.cmd == ncrt_pkg::CMD_REGISTER) begin
          if (hit) begin
            chans[idx]    = it.channel;
            r.channel_out = it.channel;
          end else if (used < ncrt_pkg::ENTRIES) begin
            names[used]   = key;
            chans[used]   = it.channel;
            used++;
            r.channel_out = it.channel;
          end else begin
            r.status = ncrt_pkg::ST_REJECT;
          end
        end else if (hit) begin
          r.channel_out = chans[idx];
        end else begin
          r.status = ncrt_pkg::ST_NOT_FOUND;
        end
      end
      replies_due.push_back(r);
    endfunction

    function void check_reply(ncrt_pkg::out_t got);
      ncrt_pkg::out_t want;
      if (replies_due.size() == 0) begin
        $display("%0t: reply with none expected, actual status %0d channel %h",
                 $time, got.status, got.channel_out);
        mismatches++;
        return;
      end
      want = replies_due.pop_front();
      checked++;
      if (got.status !== want.status) begin
        $display("%0t: status mismatch, expected %0d actual %0d",
                 $time, want.status, got.status);
        mismatches++;
      end
      if (got.channel_out !== want.channel_out) begin
        $display("%0t: channel mismatch, expected %h actual %h",
                 $time, want.channel_out, got.channel_out);
        mismatches++;
      end
    endfunction
  endclass

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  ncrt_pkg::in_t                in_data;
  logic                         out_valid;
  logic                         out_ready;
  ncrt_pkg::out_t               out_data;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [ncrt_pkg::MAGIC_W-1:0] cfg_data;

  registry_scoreboard sb;

  // Sender pacing and run statistics.
  bit          gaps_on;
  int          burst_left;
  int unsigned n_in;
  int unsigned n_cfg;
  int unsigned idle_cycles;

  // Handshake between the stimulus and the receiver for the long hold-off.
  bit          hold_start;
  int          hold_left;

  // Name pool. Lookups and registers draw from it so that names repeat, and
  // it holds more names than the table so that the table fills up.
  ncrt_pkg::key_t pool_raw [POOL];
  int unsigned    pool_len [POOL];

  name_channel_registry_table u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Result monitor: a transfer is sampled at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_reply(out_data);
  end

  // Watchdog: any transfer on any channel restarts the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver. It changes its stall pattern after each random span and, when
  // the stimulus asks for it, holds off for the long hold-off LONG_HOLD.
  initial begin
    int mode;
    int span;
    int tick;
    out_ready = 1'b0;
    tick      = 0;
    forever begin
      mode = $urandom_range(3, 0);
      span = $urandom_range(200, 20);
      repeat (span) begin
        @(negedge clk);
        tick++;
        if (hold_start) begin
          hold_left  = LONG_HOLD;
          hold_start = 1'b0;
        end
        if (hold_left > 0) begin
          out_ready <= 1'b0;
          hold_left--;
        end else begin
          case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= $urandom_range(1, 0);
            2: out_ready <= ($urandom_range(9, 0) == 0);
            default: out_ready <= ((tick % 7) < 3);
          endcase
        end
      end
    end
  end

  function automatic ncrt_pkg::key_t key_of(string s);
    ncrt_pkg::key_t k;
    k = '0;
    for (int i = 0; i < s.len(); i++) k[i / 8][(i % 8) * 8 +: 8] = s[i];
    return k;
  endfunction

  // Offers one word and waits for its transfer. The word that follows is
  // driven at a later falling edge, so valid is never dropped and raised in
  // the same step.
  task automatic offer(ncrt_pkg::in_t it);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    sb.note_transfer(it);
    n_in++;
  endtask

  task automatic rest(int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Bursts of random length separated by random gaps.
  task automatic pace();
    if (gaps_on && burst_left <= 0) begin
      rest($urandom_range(12, 1));
      burst_left = $urandom_range(20, 1);
    end
    burst_left--;
  endtask

  // Sends one request as nw words. Bytes at or past len are filled with
  // noise, which the block must ignore. Header fields on the words before
  // the last one are noise as well.
  task automatic send_request(input logic [ncrt_pkg::CMD_W-1:0] cmd,
                              input logic [ncrt_pkg::MAGIC_W-1:0] mg,
                              input logic [ncrt_pkg::LEN_W-1:0] len,
                              input logic [ncrt_pkg::CHAN_W-1:0] ch,
                              input ncrt_pkg::key_t raw, input int nw);
    ncrt_pkg::in_t it;
    logic [63:0]   w;
    for (int i = 0; i < nw; i++) begin
      w = (i < ncrt_pkg::NAME_WORDS) ? raw[i] : {$urandom, $urandom};
      for (int b = 0; b < 8; b++) begin
        if (i * 8 + b >= len) w[b * 8 +: 8] = 8'($urandom);
      end
      it.word_last = (i == nw - 1);
      it.key_word  = w;
      if (it.word_last) begin
        it.cmd     = cmd;
        it.magic   = mg;
        it.key_len = len;
        it.channel = ch;
      end else begin
        it.cmd     = ncrt_pkg::CMD_W'($urandom);
        it.magic   = $urandom;
        it.key_len = ncrt_pkg::LEN_W'($urandom);
        it.channel = {$urandom, $urandom};
      end
      pace();
      offer(it);
    end
  endtask

  task automatic write_magic(logic [ncrt_pkg::MAGIC_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    sb.set_magic(v);
    n_cfg++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Lowers valid, waits for every owed reply, then lets a request that gives
  // no reply run out before anything else happens.
  task automatic drain();
    rest(1);
    forever begin
      @(posedge clk);
      if (sb.replies_pending() == 0) break;
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic void build_pool();
    int unsigned len;
    for (int p = 0; p < POOL; p++) begin
      len = ($urandom_range(4, 0) == 0) ? $urandom_range(63, 17) : $urandom_range(16, 1);
      pool_len[p] = len;
      pool_raw[p] = '0;
      for (int b = 0; b < len; b++) begin
        // A rare zero byte cuts the name short, as a string terminator would.
        pool_raw[p][b / 8][(b % 8) * 8 +: 8] =
          ($urandom_range(24, 0) == 0) ? 8'h00 : 8'($urandom_range(255, 1));
      end
    end
  endfunction

  // Mostly well-formed registers and lookups on pool names; the rest are
  // bad commands, bad lengths and wrong magics.
  task automatic random_request(logic [ncrt_pkg::MAGIC_W-1:0] mg);
    int                           p;
    int                           kind;
    int                           nat;
    int                           nw;
    int                           pick;
    logic [ncrt_pkg::CMD_W-1:0]   cmd;
    logic [ncrt_pkg::LEN_W-1:0]   len;
    logic [ncrt_pkg::MAGIC_W-1:0] m;
    logic [ncrt_pkg::CHAN_W-1:0]  ch;
    p    = $urandom_range(POOL - 1, 0);
    kind = $urandom_range(99, 0);
    len  = ncrt_pkg::LEN_W'(pool_len[p]);
    m    = mg;
    ch   = {$urandom, $urandom};
    pick = $urandom_range(19, 0);
    if (pick == 0) ch = '0;
    else if (pick == 1) ch = '1;
    if (kind < 45) begin
      cmd = ncrt_pkg::CMD_REGISTER;
    end else if (kind < 85) begin
      cmd = ncrt_pkg::CMD_LOOKUP;
    end else if (kind < 90) begin
      cmd = ncrt_pkg::CMD_W'($urandom_range(65535, 2));
    end else begin
      cmd = $urandom_range(1, 0) ? ncrt_pkg::CMD_REGISTER : ncrt_pkg::CMD_LOOKUP;
      if (kind < 95) begin
        len = ($urandom_range(2, 0) == 0) ? '0 : ncrt_pkg::LEN_W'($urandom_range(65535, 64));
      end else begin
        m = mg ^ ($urandom | 32'h1);
      end
    end
    nat  = (pool_len[p] + 7) / 8;
    pick = $urandom_range(9, 0);
    if (pick == 0) nw = $urandom_range(nat, 1);
    else if (pick == 1) nw = $urandom_range(10, nat + 1);
    else nw = nat;
    send_request(cmd, m, len, ch, pool_raw[p], nw);
  endtask

  initial begin
    logic [ncrt_pkg::MAGIC_W-1:0] magics [4];
    ncrt_pkg::key_t               k;
    logic [ncrt_pkg::MAGIC_W-1:0] m;
    int unsigned                  phase_end;

    sb          = new();
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    gaps_on     = 1'b1;
    burst_left  = 0;
    n_in        = 0;
    n_cfg       = 0;
    idle_cycles = 0;
    hold_start  = 1'b0;
    hold_left   = 0;
    build_pool();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, served under the all-ones magic.
    m = '1;
    write_magic(m);
    // Lookup on an empty table misses; then a register, a hit, an update
    // with the channel at its extremes, and a hit on the new value.
    send_request(ncrt_pkg::CMD_LOOKUP,   m, 3, 64'h1234, key_of("abc"), 1);
    send_request(ncrt_pkg::CMD_REGISTER, m, 3, '0, key_of("abc"), 1);
    send_request(ncrt_pkg::CMD_LOOKUP,   m, 3, 64'h5555, key_of("abc"), 1);
    send_request(ncrt_pkg::CMD_REGISTER, m, 3, '1, key_of("abc"), 1);
    send_request(ncrt_pkg::CMD_LOOKUP,   m, 3, '0, key_of("abc"), 1);
    // Longest name with every bit set, sent with one word too many.
    send_request(ncrt_pkg::CMD_REGISTER, m, 63, {$urandom, $urandom}, '1, 9);
    // Length of a full key and length zero are both rejected.
    send_request(ncrt_pkg::CMD_LOOKUP,   m, 64, '0, key_of("abc"), 1);
    send_request(ncrt_pkg::CMD_REGISTER, m, 0, 64'h77, key_of("abc"), 1);
    // Unknown commands.
    send_request(16'hFFFF, m, 3, '0, key_of("abc"), 1);
    send_request(16'h0002, m, 3, '0, key_of("abc"), 1);
    // Wrong magic: no reply at all.
    send_request(ncrt_pkg::CMD_LOOKUP, '0, 3, '0, key_of("abc"), 1);
    // A name whose first byte is zero is empty and still valid; any other
    // empty name finds it.
    k = '0;
    k[0][39:8] = $urandom | 32'h01010101;
    send_request(ncrt_pkg::CMD_REGISTER, m, 5, 64'hE0E0_0000_0000_0001, k, 1);
    send_request(ncrt_pkg::CMD_LOOKUP,   m, 1, '0, '0, 1);
    // Name words that never arrive count as zero.
    send_request(ncrt_pkg::CMD_REGISTER, m, 20, 64'hABCD, key_of("missingw"), 1);
    send_request(ncrt_pkg::CMD_LOOKUP,   m, 8, '0, key_of("missingw"), 1);
    drain();

    // Random part in four phases, each with its own magic. The third runs
    // without sender gaps and opens with the long receiver hold-off.
    magics[0] = '0;
    magics[1] = $urandom;
    magics[2] = $urandom;
    magics[3] = '1;
    for (int ph = 0; ph < 4; ph++) begin
      write_magic(magics[ph]);
      gaps_on    = (ph != 2);
      burst_left = 0;
      if (ph == 2) hold_start = 1'b1;
      phase_end = n_in + (ITEMS - n_in) / (4 - ph);
      while (n_in < phase_end) random_request(magics[ph]);
      drain();
    end

    $display("Run covered %0d input transfers and %0d checked replies under %0d magic writes.",
             n_in, sb.checked, n_cfg);
    $display("Table ended with %0d of %0d entries in use.", sb.used, ncrt_pkg::ENTRIES);
    if (sb.mismatches == 0 && sb.replies_pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/ncrt_pkg.sv
rtl/core/ncrt_keybuf.sv
rtl/core/ncrt_store.sv
rtl/core/name_channel_registry_table.sv
rtl/core/ncrt_checker.sv
dv/tb_top.sv
